@@ src/pas_pkg.sv @@
// Shared types, widths and codes for the periodic advection stencil step.
package pas_pkg;

	// Field widths fixed by the grid format.
	localparam int SAMPLE_W = 16;
	localparam int IDX_W    = 12;
	localparam int CFG_W    = 16;
	localparam int CFG_IX_W = 2;

	// Default row capacity.
	localparam int DEF_MAX_POINTS = 4096;

	// Register reset values.
	localparam logic [CFG_W-1:0] COURANT_RST = 16'h8000;
	localparam logic [CFG_W-1:0] GAIN_RST    = 16'h1000;

	// Register indexes on the configuration port.
	localparam logic [CFG_IX_W-1:0] CFG_SCHEME  = 2'd0;
	localparam logic [CFG_IX_W-1:0] CFG_COURANT = 2'd1;
	localparam logic [CFG_IX_W-1:0] CFG_GAIN    = 2'd2;

	// Update schemes.
	typedef enum logic [1:0] {
		SCH_UPWIND  = 2'd0,
		SCH_FTCS    = 2'd1,
		SCH_LF      = 2'd2,
		SCH_BURGERS = 2'd3
	} scheme_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_SUM,
		ST_EMIT
	} state_t;

	// Which grid point of the current sample is being updated.
	typedef enum logic [1:0] {
		JOB_MID,
		JOB_END,
		JOB_WRAP
	} job_t;

endpackage

@@ src/pas_if.sv @@
// Valid/ready stream interfaces for grid samples in and updated points out.
interface pas_in_if;
	import pas_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic                       last_in;

	modport source (output valid, output sample_in, output last_in, input ready);
	modport sink (input valid, input sample_in, input last_in, output ready);
endinterface

interface pas_out_if;
	import pas_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic [IDX_W-1:0]           point_index;
	logic                       last_out;

	modport source (output valid, output sample_out, output point_index, output last_out,
		input ready);
	modport sink (input valid, input sample_out, input point_index, input last_out,
		output ready);
endinterface

@@ src/periodic_advection_stencil_step_top.sv @@
// Periodic 1-D advection stencil step with one shared multiplier and a small sequencer.
//
//   channel  dir  payload                                 transfer when
//   in_ch    in   sample_in, last_in                      valid & ready
//   out_ch   out  sample_out, point_index, last_out       valid & ready
//   cfg      in   cfg_index, cfg_data                     cfg_we
//
// A sample that completes no point is taken in and leaves the sequencer idle. Each point
// passes through multiply, round and emit, with a second multiply in Burgers mode, where
// the shared multiplier is used twice in a row; an idle state follows the last point of a
// sample. A typical sample completes one point, and a final sample up to three. arst_n
// clears the sequencer, the row state and the registers. The emit step waits while the
// output register still holds a result that is not being taken.
module periodic_advection_stencil_step_top #(
	parameter int MAX_POINTS = pas_pkg::DEF_MAX_POINTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	pas_in_if.sink                        in_ch,
	pas_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [pas_pkg::CFG_IX_W-1:0]  cfg_index,
	input  logic [pas_pkg::CFG_W-1:0]     cfg_data
);
	import pas_pkg::*;

	localparam int CW   = $clog2(MAX_POINTS);
	localparam int PA_W = 34;
	localparam int PB_W = 18;
	localparam int PW   = PA_W + PB_W;
	localparam int RW   = 38;
	localparam int VW   = RW + 1;

	state_t state_q, state_d;
	job_t   job_q;

	scheme_t           scheme_q;
	logic [CFG_W-1:0]  courant_q;
	logic [CFG_W-1:0]  gain_q;

	logic signed [SAMPLE_W-1:0] first_q, second_q, prev_q, older_q, x_q;
	logic [CW-1:0]              count_q, k_q;
	logic                       last_q;

	logic signed [PW-1:0] prod_q;
	logic signed [RW-1:0] rnd_q;

	logic                       ovalid_q;
	logic signed [SAMPLE_W-1:0] osample_q;
	logic [IDX_W-1:0]           oindex_q;
	logic                       olast_q;

	logic in_fire, last_now, has_job, out_free, more_jobs, finish;
	logic in_ready, mul_en, sum_en, emit_go;

	// Input handshake and job decisions for the sample on offer.
	assign in_fire  = in_ch.valid && in_ready;
	assign last_now = in_ch.last_in || (count_q == CW'(MAX_POINTS - 1));
	assign has_job  = (count_q >= CW'(2)) || last_now;
	assign out_free = !ovalid_q || out_ch.ready;

	always_comb begin
		case (job_q)
			JOB_MID: more_jobs = last_q;
			JOB_END: more_jobs = (k_q != '0);
			default: more_jobs = 1'b0;
		endcase
	end

	assign finish = (in_fire && !has_job) || (emit_go && !more_jobs);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && has_job) state_d = ST_MUL1;
			end
			ST_MUL1: state_d = (scheme_q == SCH_BURGERS) ? ST_MUL2 : ST_SUM;
			ST_MUL2: state_d = ST_SUM;
			ST_SUM:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) state_d = more_jobs ? ST_MUL1 : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready = 1'b0;
		mul_en   = 1'b0;
		sum_en   = 1'b0;
		emit_go  = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_MUL1: mul_en = 1'b1;
			ST_MUL2: mul_en = 1'b1;
			ST_SUM:  sum_en = 1'b1;
			ST_EMIT: emit_go = out_free;
			default: in_ready = 1'b0;
		endcase
	end

	assign in_ch.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scheme_q  <= SCH_UPWIND;
			courant_q <= COURANT_RST;
			gain_q    <= GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCHEME:  scheme_q  <= scheme_t'(cfg_data[1:0]);
				CFG_COURANT: courant_q <= cfg_data;
				CFG_GAIN:    gain_q    <= cfg_data;
				default:     scheme_q  <= scheme_q;
			endcase
		end
	end

	// Row state. The window moves on only once every point of a sample has been emitted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= '0;
			prev_q   <= '0;
			older_q  <= '0;
			x_q      <= '0;
			count_q  <= '0;
			k_q      <= '0;
			last_q   <= 1'b0;
			job_q    <= JOB_MID;
		end else begin
			if (in_fire) begin
				x_q     <= in_ch.sample_in;
				k_q     <= count_q;
				last_q  <= last_now;
				job_q   <= (count_q >= CW'(2)) ? JOB_MID : JOB_END;
				count_q <= last_now ? '0 : count_q + CW'(1);
				if (count_q == CW'(0)) first_q  <= in_ch.sample_in;
				if (count_q == CW'(1)) second_q <= in_ch.sample_in;
			end else if (emit_go && more_jobs) begin
				job_q <= (job_q == JOB_MID) ? JOB_END : JOB_WRAP;
			end
			if (finish) begin
				older_q <= prev_q;
				prev_q  <= in_fire ? in_ch.sample_in : x_q;
			end
		end
	end

	// Stencil operands and position of the point in work.
	logic signed [SAMPLE_W-1:0] op_l, op_m, op_r;
	logic [CW-1:0]              idx_k;
	logic                       idx_last;

	always_comb begin
		op_l     = x_q;
		op_m     = x_q;
		op_r     = x_q;
		idx_k    = '0;
		idx_last = 1'b0;
		case (job_q)
			JOB_MID: begin
				op_l  = older_q;
				op_m  = prev_q;
				op_r  = x_q;
				idx_k = k_q - CW'(1);
			end
			JOB_END: begin
				idx_k = k_q;
				if (k_q == '0) begin
					idx_last = 1'b1;
				end else begin
					op_l = prev_q;
					op_m = x_q;
					op_r = first_q;
				end
			end
			default: begin
				op_l     = x_q;
				op_m     = first_q;
				op_r     = second_q;
				idx_last = 1'b1;
			end
		endcase
	end

	logic signed [SAMPLE_W:0] lr_sum, lr_diff, lm_diff, rl_diff;
	assign lr_sum  = {op_l[SAMPLE_W-1], op_l} + {op_r[SAMPLE_W-1], op_r};
	assign lr_diff = {op_l[SAMPLE_W-1], op_l} - {op_r[SAMPLE_W-1], op_r};
	assign lm_diff = {op_l[SAMPLE_W-1], op_l} - {op_m[SAMPLE_W-1], op_m};
	assign rl_diff = {op_r[SAMPLE_W-1], op_r} - {op_l[SAMPLE_W-1], op_l};

	// Shared multiplier: Courant times a difference, or the two Burgers products.
	logic signed [PA_W-1:0] mul_a;
	logic signed [PB_W-1:0] mul_b;
	logic signed [SAMPLE_W:0] mul_b17;

	always_comb begin
		case (scheme_q)
			SCH_UPWIND: mul_b17 = lm_diff;
			SCH_FTCS:   mul_b17 = rl_diff;
			SCH_LF:     mul_b17 = lr_diff;
			default:    mul_b17 = lr_sum;
		endcase
		if (state_q == ST_MUL2) begin
			mul_a = prod_q[PA_W-1:0];
			mul_b = {lr_diff[SAMPLE_W], lr_diff};
		end else begin
			mul_a = (scheme_q == SCH_BURGERS) ? {(PA_W-CFG_W)'(0), gain_q}
				: {(PA_W-CFG_W)'(0), courant_q};
			mul_b = {mul_b17[SAMPLE_W], mul_b17};
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) prod_q <= mul_a * mul_b;
	end

	// Add the scheme's base term and half an LSB, then shift down with floor.
	logic signed [PW-1:0] base_w, half_w, acc_w, shr_w;
	logic signed [PW-1:0] m_ext, lr_ext;

	assign m_ext  = PW'(op_m);
	assign lr_ext = PW'(lr_sum);

	always_comb begin
		case (scheme_q)
			SCH_UPWIND: begin
				base_w = m_ext <<< 16;
				half_w = PW'(1) <<< 15;
			end
			SCH_FTCS: begin
				base_w = '0;
				half_w = PW'(1) <<< 16;
			end
			SCH_LF: begin
				base_w = lr_ext <<< 16;
				half_w = PW'(1) <<< 16;
			end
			default: begin
				base_w = lr_ext <<< 25;
				half_w = PW'(1) <<< 25;
			end
		endcase
		acc_w = base_w + prod_q + half_w;
		case (scheme_q)
			SCH_UPWIND: shr_w = acc_w >>> 16;
			SCH_FTCS:   shr_w = acc_w >>> 17;
			SCH_LF:     shr_w = acc_w >>> 17;
			default:    shr_w = acc_w >>> 26;
		endcase
	end

	always_ff @(posedge clk) begin
		if (sum_en) rnd_q <= shr_w[RW-1:0];
	end

	// FTCS subtracts the rounded correction from the centre; then saturate.
	logic signed [VW-1:0]       val_w;
	logic signed [SAMPLE_W-1:0] sat_w;

	always_comb begin
		if (scheme_q == SCH_FTCS) val_w = VW'(op_m) - VW'(rnd_q);
		else val_w = VW'(rnd_q);
		if (val_w > VW'(32767)) sat_w = 16'sh7FFF;
		else if (val_w < -VW'(32768)) sat_w = -16'sh8000;
		else sat_w = val_w[SAMPLE_W-1:0];
	end

	// Output register. The position keeps its low bits only.
	logic [IDX_W+CW-1:0] idx_ext;
	assign idx_ext = {(IDX_W)'(0), idx_k};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit_go) begin
			ovalid_q <= 1'b1;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			osample_q <= sat_w;
			oindex_q  <= idx_ext[IDX_W-1:0];
			olast_q   <= idx_last;
		end
	end

	assign out_ch.valid       = ovalid_q;
	assign out_ch.sample_out  = osample_q;
	assign out_ch.point_index = oindex_q;
	assign out_ch.last_out    = olast_q;

	// A sample that completes no point leaves the sequencer idle.
	a_no_job_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !has_job |=> state_q == ST_IDLE)
		else $error("sequencer left idle on a sample with no point");

	// The second multiply belongs to Burgers mode only.
	a_mul2_burgers: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL2 |-> scheme_q == SCH_BURGERS)
		else $error("second multiply outside Burgers mode");

	// Loading the row's final point ends the work on that sample.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go && idx_last |=> state_q == ST_IDLE)
		else $error("work continued after the row's final point");

	// A final sample restarts the row count.
	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last_now |=> count_q == '0)
		else $error("row count not cleared after final sample");

	// Emitting never overwrites a result that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |-> !ovalid_q || out_ch.ready)
		else $error("output register overwritten before transfer");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the periodic advection stencil step: streamed rows, checked results.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pas_pkg::*;

	localparam int ROW_CAP      = DEF_MAX_POINTS;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS  = 8;
	localparam logic [CFG_IX_W-1:0] CFG_UNUSED = 2'd3;

	// One updated grid point as it should leave the block.
	typedef struct {
		logic signed [SAMPLE_W-1:0] value;
		logic [IDX_W-1:0]           index;
		logic                       last;
	} grid_point_t;

	// Row state, registers and the queue of points still owed by the block.
	class advection_scoreboard;
		scheme_t                    scheme;
		logic [CFG_W-1:0]           courant;
		logic [CFG_W-1:0]           gain;
		logic signed [SAMPLE_W-1:0] first_s;
		logic signed [SAMPLE_W-1:0] second_s;
		logic signed [SAMPLE_W-1:0] prev_s;
		logic signed [SAMPLE_W-1:0] older_s;
		int unsigned                count;
		grid_point_t                owed_points[$];
		int                         failures;

		function new();
			scheme   = SCH_UPWIND;
			courant  = COURANT_RST;
			gain     = GAIN_RST;
			first_s  = '0;
			second_s = '0;
			prev_s   = '0;
			older_s  = '0;
			count    = 0;
			failures = 0;
		endfunction

		function void write_register(logic [CFG_IX_W-1:0] index, logic [CFG_W-1:0] data);
			case (index)
				CFG_SCHEME:  scheme = scheme_t'(data[1:0]);
				CFG_COURANT: courant = data;
				CFG_GAIN:    gain = data;
				default: ;
			endcase
		endfunction

		// Divide by 2^s, rounding to nearest with ties towards plus infinity.
		function longint rounded(longint x, int s);
			return (x + (longint'(1) << (s - 1))) >>> s;
		endfunction

		// Updated value of a point from its left, centre and right samples.
		function logic signed [SAMPLE_W-1:0] stencil_point(logic signed [SAMPLE_W-1:0] l,
				logic signed [SAMPLE_W-1:0] m, logic signed [SAMPLE_W-1:0] r);
			longint lv, mv, rv, c, p, v;
			lv = longint'(l);
			mv = longint'(m);
			rv = longint'(r);
			c  = longint'(courant);
			case (scheme)
				SCH_UPWIND: v = mv + rounded(c * (lv - mv), 16);
				SCH_FTCS:   v = mv - rounded(c * (rv - lv), 17);
				SCH_LF:     v = rounded((lv + rv) * 65536 + c * (lv - rv), 17);
				default: begin
					p = longint'(gain) * (lv + rv);
					v = rounded((lv + rv) * (longint'(1) << 25) + p * (lv - rv), 26);
				end
			endcase
			if (v > 32767)
				v = 32767;
			else if (v < -32768)
				v = -32768;
			return v[SAMPLE_W-1:0];
		endfunction

		function void owe_point(logic signed [SAMPLE_W-1:0] value, int unsigned index,
				logic last);
			grid_point_t pt;
			pt.value = value;
			pt.index = index[IDX_W-1:0];
			pt.last  = last;
			owed_points.push_back(pt);
		endfunction

		// An accepted sample completes its left neighbour and, at the row end, the wrap points.
		function void note_sample(logic signed [SAMPLE_W-1:0] x, logic last_in);
			int unsigned k;
			logic        row_end;
			k = count;
			row_end = last_in || (k >= ROW_CAP - 1);
			if (k == 0)
				first_s = x;
			if (k == 1)
				second_s = x;
			if (k >= 2)
				owe_point(stencil_point(older_s, prev_s, x), k - 1, 1'b0);
			if (row_end) begin
				if (k == 0) begin
					owe_point(stencil_point(x, x, x), 0, 1'b1);
				end else begin
					owe_point(stencil_point(prev_s, x, first_s), k, 1'b0);
					owe_point(stencil_point(x, first_s, second_s), 0, 1'b1);
				end
			end
			older_s = prev_s;
			prev_s  = x;
			count   = row_end ? 0 : k + 1;
		endfunction

		// Compare one result transfer with the oldest owed point.
		function void check_point(logic signed [SAMPLE_W-1:0] value, logic [IDX_W-1:0] index,
				logic last);
			grid_point_t pt;
			if (owed_points.size() == 0) begin
				$error("unexpected result: sample_out %0d, point_index %0d", value, index);
				failures++;
				return;
			end
			pt = owed_points.pop_front();
			if (value !== pt.value) begin
				$error("sample_out: expected %0d, got %0d", pt.value, value);
				failures++;
			end
			if (index !== pt.index) begin
				$error("point_index: expected %0d, got %0d", pt.index, index);
				failures++;
			end
			if (last !== pt.last) begin
				$error("last_out: expected %0b, got %0b", pt.last, last);
				failures++;
			end
		endfunction

		function int pending();
			return owed_points.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_IX_W-1:0] cfg_index;
	logic [CFG_W-1:0]    cfg_data;

	pas_in_if  in_ch ();
	pas_out_if out_ch ();

	advection_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	int cycle_count;

	periodic_advection_stencil_step_top #(
		.MAX_POINTS(ROW_CAP)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch.sink),
		.out_ch    (out_ch.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 2 ns clock.
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("periodic_advection_stencil_step_top verification failed");
			$finish;
		end
	end

	// Result side: check each transfer, then choose ready for the next cycle.
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
				sb.check_point(out_ch.sample_out, out_ch.point_index, out_ch.last_out);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] random_sample();
		logic [SAMPLE_W-1:0] raw;
		raw = SAMPLE_W'($urandom);
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return -16'sh8000;
			2: return $signed(SAMPLE_W'($urandom_range(0, 127))) - 16'sd64;
			default: return $signed(raw);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] random_register();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return CFG_W'($urandom);
		endcase
	endfunction

	// Offer one sample, with random gaps, and hold it until the transfer.
	task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.sample_in <= s;
		in_ch.last_in   <= last;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		sb.note_sample(s, last);
	endtask

	task automatic send_row(int len);
		for (int i = 0; i < len; i++)
			send_sample(random_sample(), i == len - 1);
	endtask

	// Stop offering and wait for every owed point plus the sequencer's tail.
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all registers back to back; the unused index must change nothing.
	task automatic configure(scheme_t sch, logic [CFG_W-1:0] c, logic [CFG_W-1:0] g);
		logic [CFG_W-1:0] sch_word;
		logic [CFG_W-1:0] junk;
		sch_word = CFG_W'($urandom);
		sch_word[1:0] = sch;
		junk = CFG_W'($urandom);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SCHEME;
		cfg_data  <= sch_word;
		@(posedge clk);
		sb.write_register(CFG_SCHEME, sch_word);
		cfg_index <= CFG_COURANT;
		cfg_data  <= c;
		@(posedge clk);
		sb.write_register(CFG_COURANT, c);
		cfg_index <= CFG_GAIN;
		cfg_data  <= g;
		@(posedge clk);
		sb.write_register(CFG_GAIN, g);
		cfg_index <= CFG_UNUSED;
		cfg_data  <= junk;
		@(posedge clk);
		sb.write_register(CFG_UNUSED, junk);
		cfg_we <= 1'b0;
	endtask

	// Main sequence: reset, directed rows, then random phases.
	initial begin
		int sent;
		int len;
		sb = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = 0;
		cycle_count    = 0;
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= CFG_SCHEME;
		cfg_data        <= '0;
		in_ch.valid     <= 1'b0;
		in_ch.sample_in <= '0;
		in_ch.last_in   <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset registers: a single-sample row and a two-sample row.
		send_sample(16'sh7FFF, 1'b1);
		send_sample(-16'sh8000, 1'b0);
		send_sample(16'sh7FFF, 1'b1);

		// Every scheme on alternating extremes, with extreme register values.
		for (int s = 0; s < 4; s++) begin
			settle();
			case (s)
				0: configure(SCH_UPWIND, 16'hFFFF, 16'h0000);
				1: configure(SCH_FTCS, 16'hFFFF, 16'hFFFF);
				2: configure(SCH_LF, 16'h0000, 16'hFFFF);
				default: configure(SCH_BURGERS, 16'h0000, 16'hFFFF);
			endcase
			send_sample(16'sh7FFF, 1'b0);
			send_sample(-16'sh8000, 1'b0);
			send_sample(16'sh7FFF, 1'b0);
			send_sample(-16'sh8000, 1'b1);
		end

		// Random rows under each idling mode, two settings per mode.
		for (int ph = 0; ph < 8; ph++) begin
			settle();
			configure(scheme_t'(ph % 4), random_register(), random_register());
			case (ph / 2)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 76;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 76;
				end
				default: begin
					send_idle_pct  = 27;
					recv_stall_pct = 27;
				end
			endcase
			// Long receiver hold-off so the block backs up onto its input.
			if (ph == 1)
				hold_cycles = 300;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 7) == 0)
					len = $urandom_range(9, 24);
				else
					len = $urandom_range(1, 8);
				send_row(len);
				sent += len;
				// Sender pause until the block has delivered everything.
				if (ph == 6 && sent >= PHASE_ITEMS / 2 && sent - len < PHASE_ITEMS / 2) begin
					in_ch.valid <= 1'b0;
					while (sb.pending() != 0)
						@(posedge clk);
				end
			end
		end

		settle();
		if (sb.failures == 0)
			$display("periodic_advection_stencil_step_top verification clean");
		else
			$display("periodic_advection_stencil_step_top verification failed");
		$finish;
	end
endmodule

@@ filelist.f @@
src/pas_pkg.sv
src/pas_if.sv
src/periodic_advection_stencil_step_top.sv
test/tb_top.sv
